FILE: hdl/scta_pkg.sv
// Package for the scan code set 1 to ASCII translator with character FIFO.
// Holds word types, key codes and the plain and shifted character tables.
// No dependencies.
package scta_pkg;

    localparam int SCTA_FIFO_DEPTH = 64;

    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [6:0] KEY_LSHIFT = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT = 7'h36;
    localparam logic [6:0] KEY_CAPS   = 7'h3A;

    typedef struct packed {
        logic       op;
        logic [7:0] scan_byte;
    } req_t;

    typedef struct packed {
        logic       is_key_event;
        logic       released;
        logic [6:0] key_code;
        logic [1:0] modifiers;
        logic [6:0] ascii;
        logic       dropped;
        logic [6:0] read_char;
    } rsp_t;

    // classified word handed from front to back
    typedef struct packed {
        logic       is_key_event;
        logic       released;
        logic [6:0] key_code;
        logic [1:0] modifiers;
        logic [6:0] ascii;
    } cls_t;

    function automatic logic [6:0] plain_char(input logic [6:0] key);
        logic [6:0] c;
        case (key)
            7'h01: c = 7'h1B;
            7'h02: c = 7'h31;
            7'h03: c = 7'h32;
            7'h04: c = 7'h33;
            7'h05: c = 7'h34;
            7'h06: c = 7'h35;
            7'h07: c = 7'h36;
            7'h08: c = 7'h37;
            7'h09: c = 7'h38;
            7'h0A: c = 7'h39;
            7'h0B: c = 7'h30;
            7'h0C: c = 7'h2D;
            7'h0D: c = 7'h3D;
            7'h0E: c = 7'h08;
            7'h0F: c = 7'h09;
            7'h10: c = 7'h71;
            7'h11: c = 7'h77;
            7'h12: c = 7'h65;
            7'h13: c = 7'h72;
            7'h14: c = 7'h74;
            7'h15: c = 7'h79;
            7'h16: c = 7'h75;
            7'h17: c = 7'h69;
            7'h18: c = 7'h6F;
            7'h19: c = 7'h70;
            7'h1A: c = 7'h5B;
            7'h1B: c = 7'h5D;
            7'h1C: c = 7'h0A;
            7'h1E: c = 7'h61;
            7'h1F: c = 7'h73;
            7'h20: c = 7'h64;
            7'h21: c = 7'h66;
            7'h22: c = 7'h67;
            7'h23: c = 7'h68;
            7'h24: c = 7'h6A;
            7'h25: c = 7'h6B;
            7'h26: c = 7'h6C;
            7'h27: c = 7'h3B;
            7'h28: c = 7'h27;
            7'h29: c = 7'h60;
            7'h2B: c = 7'h5C;
            7'h2C: c = 7'h7A;
            7'h2D: c = 7'h78;
            7'h2E: c = 7'h63;
            7'h2F: c = 7'h76;
            7'h30: c = 7'h62;
            7'h31: c = 7'h6E;
            7'h32: c = 7'h6D;
            7'h33: c = 7'h2C;
            7'h34: c = 7'h2E;
            7'h35: c = 7'h2F;
            7'h37: c = 7'h2A;
            7'h39: c = 7'h20;
            7'h47: c = 7'h37;
            7'h48: c = 7'h38;
            7'h49: c = 7'h39;
            7'h4A: c = 7'h2D;
            7'h4B: c = 7'h34;
            7'h4C: c = 7'h35;
            7'h4D: c = 7'h36;
            7'h4E: c = 7'h2B;
            7'h4F: c = 7'h31;
            7'h50: c = 7'h32;
            7'h51: c = 7'h33;
            7'h52: c = 7'h30;
            7'h53: c = 7'h2E;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] shifted_char(input logic [6:0] key);
        logic [6:0] c;
        case (key)
            7'h01: c = 7'h1B;
            7'h02: c = 7'h21;
            7'h03: c = 7'h40;
            7'h04: c = 7'h23;
            7'h05: c = 7'h24;
            7'h06: c = 7'h25;
            7'h07: c = 7'h5E;
            7'h08: c = 7'h26;
            7'h09: c = 7'h2A;
            7'h0A: c = 7'h28;
            7'h0B: c = 7'h29;
            7'h0C: c = 7'h5F;
            7'h0D: c = 7'h2B;
            7'h0E: c = 7'h08;
            7'h0F: c = 7'h09;
            7'h10: c = 7'h51;
            7'h11: c = 7'h57;
            7'h12: c = 7'h45;
            7'h13: c = 7'h52;
            7'h14: c = 7'h54;
            7'h15: c = 7'h59;
            7'h16: c = 7'h55;
            7'h17: c = 7'h49;
            7'h18: c = 7'h4F;
            7'h19: c = 7'h50;
            7'h1A: c = 7'h7B;
            7'h1B: c = 7'h7D;
            7'h1C: c = 7'h0A;
            7'h1E: c = 7'h41;
            7'h1F: c = 7'h53;
            7'h20: c = 7'h44;
            7'h21: c = 7'h46;
            7'h22: c = 7'h47;
            7'h23: c = 7'h48;
            7'h24: c = 7'h4A;
            7'h25: c = 7'h4B;
            7'h26: c = 7'h4C;
            7'h27: c = 7'h3A;
            7'h28: c = 7'h22;
            7'h29: c = 7'h7E;
            7'h2B: c = 7'h7C;
            7'h2C: c = 7'h5A;
            7'h2D: c = 7'h58;
            7'h2E: c = 7'h43;
            7'h2F: c = 7'h56;
            7'h30: c = 7'h42;
            7'h31: c = 7'h4E;
            7'h32: c = 7'h4D;
            7'h33: c = 7'h3C;
            7'h34: c = 7'h3E;
            7'h35: c = 7'h3F;
            7'h37: c = 7'h2A;
            7'h39: c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/scta_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/scta_front.sv
// Front end: accepts request words, tracks shift and caps lock, translates keys.
// Depends on scta_pkg.
module scta_front
    import scta_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic cls_valid,
    input  logic cls_ready,
    output cls_t cls
);

    logic       shift_reg, shift_next;
    logic       caps_reg, caps_next;
    logic       fire;
    logic       rel;
    logic [6:0] key;
    logic [6:0] p_ch, s_ch, ch;

    assign req_ready = cls_ready;
    assign cls_valid = req_valid;
    assign fire      = req_valid && cls_ready;
    assign rel       = req.scan_byte[7];
    assign key       = req.scan_byte[6:0];
    assign p_ch      = plain_char(key);
    assign s_ch      = shifted_char(key);

    always_comb
    begin
        shift_next = shift_reg;
        caps_next  = caps_reg;
        if (req.op == OP_SCAN)
        begin
            if (key == KEY_LSHIFT || key == KEY_RSHIFT)
            begin
                shift_next = !rel;
            end
            else if (key == KEY_CAPS && !rel)
            begin
                caps_next = !caps_reg;
            end
        end
    end

    // lookup uses modifiers after this byte
    always_comb
    begin
        if (caps_next && !shift_next)
        begin
            ch = (s_ch inside {[7'h41:7'h5A]}) ? s_ch : p_ch;
        end
        else if (shift_next && !caps_next)
        begin
            ch = s_ch;
        end
        else
        begin
            ch = p_ch;
        end
    end

    always_comb
    begin
        cls = '0;
        if (req.op == OP_SCAN)
        begin
            cls.is_key_event = 1'b1;
            cls.released     = rel;
            cls.key_code     = key;
            cls.modifiers    = {caps_reg, shift_reg};
            cls.ascii        = rel ? 7'h00 : ch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 1'b0;
            caps_reg  <= 1'b0;
        end
        else if (fire)
        begin
            shift_reg <= shift_next;
            caps_reg  <= caps_next;
        end
    end

endmodule

FILE: hdl/scta_queue.sv
// Two-entry queue of classified words between front and back.
// Depends on scta_pkg.
module scta_queue
    import scta_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cls_t in_word,
    output logic out_valid,
    input  logic out_ready,
    output cls_t out_word
);

    cls_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_word  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: hdl/scta_back.sv
// Back end: character ring FIFO push and pop, result register.
// Depends on scta_pkg and scta_ram.
module scta_back
    import scta_pkg::*;
#(
    parameter int FIFO_DEPTH = SCTA_FIFO_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cls_valid,
    output logic cls_ready,
    input  cls_t cls,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(FIFO_DEPTH - 1);

    logic [AW-1:0] wr_idx_reg, rd_idx_reg;
    logic [AW-1:0] wr_inc, rd_inc;
    logic          fire, full, empty, push, pop, lost;
    logic          valid_reg;
    logic          popped_reg;
    logic          dropped_reg;
    cls_t          word_reg;
    logic [6:0]    rdata;

    assign wr_inc = (wr_idx_reg == LAST) ? '0 : wr_idx_reg + 1'b1;
    assign rd_inc = (rd_idx_reg == LAST) ? '0 : rd_idx_reg + 1'b1;
    assign full   = (wr_inc == rd_idx_reg);
    assign empty  = (wr_idx_reg == rd_idx_reg);

    assign cls_ready = !valid_reg || rsp_ready;
    assign fire      = cls_valid && cls_ready;

    assign push = fire && cls.is_key_event && (cls.ascii != 7'h00) && !full;
    assign lost = cls.is_key_event && (cls.ascii != 7'h00) && full;
    assign pop  = fire && !cls.is_key_event && !empty;

    scta_ram #(
        .WIDTH (7),
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (push),
        .waddr (wr_idx_reg),
        .wdata (cls.ascii),
        .re    (pop),
        .raddr (rd_idx_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            word_reg    <= cls;
            dropped_reg <= lost;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            valid_reg  <= 1'b0;
            popped_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_idx_reg <= wr_inc;
            end
            if (pop)
            begin
                rd_idx_reg <= rd_inc;
            end
            if (fire)
            begin
                valid_reg  <= 1'b1;
                popped_reg <= pop;
            end
            else if (rsp_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid        = valid_reg;
    assign rsp.is_key_event = word_reg.is_key_event;
    assign rsp.released     = word_reg.released;
    assign rsp.key_code     = word_reg.key_code;
    assign rsp.modifiers    = word_reg.modifiers;
    assign rsp.ascii        = word_reg.ascii;
    assign rsp.dropped      = dropped_reg;
    assign rsp.read_char    = popped_reg ? rdata : 7'h00;

endmodule

FILE: hdl/scancode_to_ascii_with_fifo_top.sv
// Top level of the scan code set 1 to ASCII translator with character FIFO.
// Depends on scta_pkg, scta_front, scta_queue, scta_back.
//
// Takes one request word per cycle unless held by back-pressure from rsp_ready:
// a set 1 scan byte (op 0) or a character read (op 1), and gives one response
// word for each, in order. The front translates keys and tracks shift and caps
// lock in the cycle a word is accepted; a two-entry queue feeds the back, which
// owns the character FIFO (FIFO_DEPTH entries, FIFO_DEPTH - 1 usable) in a RAM
// with one write and one registered read port. Throughput is one word per cycle
// while rsp_ready stays high, set by the back handling one queued word and one
// RAM access per cycle; a word passes through a queue slot register and then the
// back's result register. The RAM needs no clearing after reset.
module scancode_to_ascii_with_fifo_top
    import scta_pkg::*;
#(
    parameter int FIFO_DEPTH = SCTA_FIFO_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    logic f_valid, f_ready;
    cls_t f_word;
    logic b_valid, b_ready;
    cls_t b_word;

    scta_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cls_valid (f_valid),
        .cls_ready (f_ready),
        .cls       (f_word)
    );

    scta_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_word   (f_word),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_word  (b_word)
    );

    scta_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_valid (b_valid),
        .cls_ready (b_ready),
        .cls       (b_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

FILE: hdl/scta_checker.sv
// Port-level checks for scancode_to_ascii_with_fifo_top, bound to the top level.
// Depends on scta_pkg.
module scta_checker
    import scta_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // read word carries only read_char
    a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.is_key_event |->
            !rsp.released && rsp.key_code == 7'h00 && rsp.modifiers == 2'b00 &&
            rsp.ascii == 7'h00 && !rsp.dropped)
        else $error("read word has key fields set");

    // key word never pops a character; release gives no character
    a_key_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.is_key_event |->
            rsp.read_char == 7'h00 && (!rsp.released || rsp.ascii == 7'h00))
        else $error("key word has bad character fields");

    // only a nonzero press character can be dropped
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.dropped |-> rsp.is_key_event && !rsp.released &&
            rsp.ascii != 7'h00)
        else $error("dropped flag without a pressed character");

    // no response right after reset
    a_no_early: assert property (@(posedge clk)
        !$past(rst_n) |-> !rsp_valid)
        else $error("response valid right after reset");

endmodule

bind scancode_to_ascii_with_fifo_top scta_checker u_scta_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
